[hw/rtl/checked_integer_fold_alu_top_assert.svh]
// Assertion macros for the fold ALU top level.
`ifndef CHECKED_INTEGER_FOLD_ALU_TOP_ASSERT_SVH
`define CHECKED_INTEGER_FOLD_ALU_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define CFA_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CFA_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/cfa_pkg.sv]
`default_nettype none
package cfa_pkg;

  typedef logic [2:0] op_t;
  typedef logic [1:0] err_t;

  localparam op_t OP_ADD = 3'd0;
  localparam op_t OP_SUB = 3'd1;
  localparam op_t OP_MUL = 3'd2;
  localparam op_t OP_DIV = 3'd3;
  localparam op_t OP_MOD = 3'd4;
  localparam op_t OP_POW = 3'd5;
  localparam op_t OP_MIN = 3'd6;
  localparam op_t OP_MAX = 3'd7;

  localparam err_t ERR_NONE     = 2'd0;
  localparam err_t ERR_OVERFLOW = 2'd1;
  localparam err_t ERR_DIVZERO  = 2'd2;
  localparam err_t ERR_NEGEXP   = 2'd3;

endpackage
`default_nettype wire

[hw/rtl/cfa_in_if.sv]
`default_nettype none
interface cfa_in_if
  import cfa_pkg::*;
;
  logic        valid;
  logic        ready;
  op_t         op;
  logic [63:0] operand;
  logic        first;
  logic        last;

  modport source (output valid, op, operand, first, last, input ready);
  modport sink (input valid, op, operand, first, last, output ready);
endinterface
`default_nettype wire

[hw/rtl/cfa_out_if.sv]
`default_nettype none
interface cfa_out_if
  import cfa_pkg::*;
;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  err_t        error;

  modport source (output valid, value, error, input ready);
  modport sink (input valid, value, error, output ready);
endinterface
`default_nettype wire

[hw/rtl/cfa_mul.sv]
`default_nettype none
module cfa_mul #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic              done,
  output logic [W-1:0]      prod
);
  localparam int HW = (W + 1) / 2;
  localparam int PW = 4 * HW;
  localparam logic [PW-1:0] MAXMAG = PW'({(W-1){1'b1}});
  localparam logic [W-1:0]  SAT = W'(1) << (W - 1);

  logic            busy;
  logic [2:0]      cnt;
  logic [2*HW-1:0] la, lb, pp;
  logic [1:0]      psel;
  logic [PW-1:0]   acc, pp_ext, pp_sh;
  logic [HW-1:0]   ahalf, bhalf;
  logic [1:0]      sh;

  // pick the halves for this partial product
  assign ahalf = cnt[1] ? la[2*HW-1:HW] : la[HW-1:0];
  assign bhalf = cnt[0] ? lb[2*HW-1:HW] : lb[HW-1:0];

  // align the previous partial product
  assign sh     = {1'b0, psel[1]} + {1'b0, psel[0]};
  assign pp_ext = PW'(pp);
  always_comb begin
    case (sh)
      2'd0:    pp_sh = pp_ext;
      2'd1:    pp_sh = pp_ext << HW;
      default: pp_sh = pp_ext << (2 * HW);
    endcase
  end

  // sequence: four products, each accumulated in the cycle after it is formed
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'd5) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      la  <= (2*HW)'(a);
      lb  <= (2*HW)'(b);
      acc <= '0;
    end else if (busy) begin
      if (cnt < 3'd4) begin
        pp   <= ahalf * bhalf;
        psel <= cnt[1:0];
      end
      if (cnt >= 3'd1 && cnt <= 3'd4) acc <= acc + pp_sh;
    end
  end

  // saturate beyond the magnitude limit
  assign done = busy && (cnt == 3'd5);
  assign prod = (acc > MAXMAG) ? SAT : acc[W-1:0];
endmodule
`default_nettype wire

[hw/rtl/cfa_div.sv]
`default_nettype none
module cfa_div #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] n,
  input  wire logic [W-1:0] d,
  output logic              done,
  output logic [W-1:0]      quo,
  output logic [W-1:0]      rmd
);
  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  nq, dq, rem;
  logic [W:0]    rem_sh, diff;
  logic          take;

  // one restoring step a cycle
  assign rem_sh = {rem, nq[W-1]};
  assign diff   = rem_sh - {1'b0, dq};
  assign take   = (rem_sh >= {1'b0, dq});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == CW'(W)) busy <= 1'b0;
      else               cnt  <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= n;
      dq  <= d;
      rem <= '0;
    end else if (busy && cnt != CW'(W)) begin
      rem <= take ? diff[W-1:0] : rem_sh[W-1:0];
      nq  <= {nq[W-2:0], take};
    end
  end

  assign done = busy && (cnt == CW'(W));
  assign quo  = nq;
  assign rmd  = rem;
endmodule
`default_nettype wire

[hw/rtl/checked_integer_fold_alu_top.sv]
// Checked integer fold ALU.
// Channel req carries list words (op, operand, first, last); channel rsp
// carries one result word (value, error) for each word marked last.
// Both use valid/ready; a word moves when both are high.
// A word marked first loads the accumulator and the operation; later words
// fold into it. Only the low DATA_WIDTH bits of operand are used.
// Work per word, from acceptance to ready again:
//   add, sub, min, max, first word: the execute step alone
//   mul: four half-width partial products on one multiplier
//   div, mod: restoring divider, one bit a cycle
//   pow: a multiply for each set exponent bit and a square for each bit
//   below the top (square and multiply share the multiplier),
//   ending early on overflow.
// A last word then passes the emit step, which loads the output register.
// ready is low while a word is in work. The output register decouples the
// sides: words without last are taken while a result waits; a last word
// holds in its emit step until rsp is free.
// Synchronous reset clears the accumulator, selects add and clears the
// error; no result is pending after reset.
`default_nettype none
module checked_integer_fold_alu_top
  import cfa_pkg::*;
#(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  cfa_in_if.sink    req,
  cfa_out_if.source rsp
);
  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] MAXMAG = {1'b0, {(W-1){1'b1}}};
  localparam logic [W:0]   MINVAL = {2'b11, {(W-1){1'b0}}};

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_PCHK = 4'd4;
  localparam logic [3:0] S_PMR  = 4'd5;
  localparam logic [3:0] S_PSHF = 4'd6;
  localparam logic [3:0] S_PMS  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0]   state, state_next, fin_state;
  logic [W-1:0] acc, acc_next, xq;
  op_t          hop, hop_next;
  err_t         err, err_next;
  op_t          xq_op;
  logic         firstq, lastq;
  logic [W-1:0] r, r_next, base, base_next, e, e_next;
  logic         ovalid;
  logic [63:0]  ovalue;
  err_t         oerror;

  logic         na, nb, is_sub;
  logic [W-1:0] ma, mb;
  logic [W:0]   aext, xext, sum;
  logic         sum_ovf;

  logic         st_en, st_neg;
  logic [W-1:0] st_mag;
  logic         fl_en;
  err_t         fl_code;

  logic         mul_start, mul_done, div_start, div_done;
  logic [W-1:0] mul_a, mul_b, prod, quo, rmd;
  logic         prod_sat;

  // sign and magnitude of both sides
  assign na = acc[W-1];
  assign nb = xq[W-1];
  assign ma = na ? (W'(0) - acc) : acc;
  assign mb = nb ? (W'(0) - xq) : xq;

  // one adder for add and subtract
  assign is_sub  = (hop == OP_SUB);
  assign aext    = {acc[W-1], acc};
  assign xext    = {xq[W-1], xq};
  assign sum     = aext + (is_sub ? ~xext : xext) + (W+1)'(is_sub);
  assign sum_ovf = (sum[W] != sum[W-1]) || (sum == MINVAL);

  assign prod_sat  = prod[W-1];
  assign fin_state = lastq ? S_EMIT : S_IDLE;

  cfa_mul #(.W(W)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(prod)
  );

  cfa_div #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .n(ma), .d(mb),
    .done(div_done), .quo(quo), .rmd(rmd)
  );

  // sequencer
  always_comb begin
    state_next = state;
    acc_next   = acc;
    hop_next   = hop;
    err_next   = err;
    r_next     = r;
    base_next  = base;
    e_next     = e;
    st_en      = 1'b0;
    st_neg     = 1'b0;
    st_mag     = '0;
    fl_en      = 1'b0;
    fl_code    = ERR_NONE;
    mul_start  = 1'b0;
    mul_a      = r;
    mul_b      = base;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = fin_state;
        if (firstq) begin
          acc_next = xq;
          hop_next = xq_op;
          err_next = ERR_NONE;
          if (lastq && xq_op == OP_SUB) begin
            st_en  = 1'b1;
            st_neg = !nb;
            st_mag = mb;
          end
        end else if (err == ERR_NONE) begin
          case (hop) inside
            OP_ADD, OP_SUB: begin
              if (sum_ovf) begin
                fl_en   = 1'b1;
                fl_code = ERR_OVERFLOW;
              end else begin
                acc_next = sum[W-1:0];
              end
            end
            OP_MUL: begin
              mul_start  = 1'b1;
              mul_a      = ma;
              mul_b      = mb;
              state_next = S_MUL;
            end
            OP_DIV, OP_MOD: begin
              if (mb == '0) begin
                fl_en   = 1'b1;
                fl_code = ERR_DIVZERO;
              end else begin
                div_start  = 1'b1;
                state_next = S_DIV;
              end
            end
            OP_POW: begin
              if (nb) begin
                fl_en   = 1'b1;
                fl_code = ERR_NEGEXP;
              end else if (ma == '0) begin
                st_en  = 1'b1;
                st_mag = (mb == '0) ? W'(1) : W'(0);
              end else begin
                r_next     = W'(1);
                base_next  = ma;
                e_next     = mb;
                state_next = S_PCHK;
              end
            end
            OP_MIN: begin
              if ($signed(xq) < $signed(acc)) acc_next = xq;
            end
            default: begin
              if ($signed(xq) > $signed(acc)) acc_next = xq;
            end
          endcase
        end
      end
      S_MUL: begin
        if (mul_done) begin
          st_en      = 1'b1;
          st_neg     = na ^ nb;
          st_mag     = prod;
          state_next = fin_state;
        end
      end
      S_DIV: begin
        if (div_done) begin
          st_en      = 1'b1;
          st_neg     = (hop == OP_DIV) ? (na ^ nb) : na;
          st_mag     = (hop == OP_DIV) ? quo : rmd;
          state_next = fin_state;
        end
      end
      S_PCHK: begin
        if (e == '0) begin
          st_en      = 1'b1;
          st_neg     = na && xq[0];
          st_mag     = r;
          state_next = fin_state;
        end else if (e[0]) begin
          mul_start  = 1'b1;
          state_next = S_PMR;
        end else begin
          state_next = S_PSHF;
        end
      end
      S_PMR: begin
        if (mul_done) begin
          if (prod_sat) begin
            fl_en      = 1'b1;
            fl_code    = ERR_OVERFLOW;
            state_next = fin_state;
          end else begin
            r_next     = prod;
            state_next = S_PSHF;
          end
        end
      end
      S_PSHF: begin
        e_next = e >> 1;
        if ((e >> 1) == '0) begin
          st_en      = 1'b1;
          st_neg     = na && xq[0];
          st_mag     = r;
          state_next = fin_state;
        end else begin
          mul_start  = 1'b1;
          mul_a      = base;
          state_next = S_PMS;
        end
      end
      S_PMS: begin
        // a saturated square is an overflow at once: a set exponent bit remains
        if (mul_done) begin
          if (prod_sat) begin
            fl_en      = 1'b1;
            fl_code    = ERR_OVERFLOW;
            state_next = fin_state;
          end else begin
            base_next  = prod;
            state_next = S_PCHK;
          end
        end
      end
      S_EMIT: begin
        if (!ovalid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    // write back a sign/magnitude result with the limit check
    if (st_en) begin
      if (st_mag > MAXMAG) begin
        err_next = ERR_OVERFLOW;
        acc_next = '0;
      end else begin
        acc_next = st_neg ? (W'(0) - st_mag) : st_mag;
      end
    end
    if (fl_en) begin
      err_next = fl_code;
      acc_next = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc   <= '0;
      hop   <= OP_ADD;
      err   <= ERR_NONE;
    end else begin
      state <= state_next;
      acc   <= acc_next;
      err   <= err_next;
      hop   <= hop_next;
    end
  end

  // latch the accepted word
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      xq     <= req.operand[W-1:0];
      xq_op  <= req.op;
      firstq <= req.first;
      lastq  <= req.last;
    end
    r    <= r_next;
    base <= base_next;
    e    <= e_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == S_EMIT && (!ovalid || rsp.ready)) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!ovalid || rsp.ready)) begin
      ovalue <= (err != ERR_NONE) ? 64'd0 : 64'($signed(acc));
      oerror <= err;
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = ovalid;
  assign rsp.value = ovalue;
  assign rsp.error = oerror;

  `include "checked_integer_fold_alu_top_assert.svh"

  `CFA_CHECK_NOW(a_err_zero, rsp.valid && rsp.error != ERR_NONE, rsp.value == 64'd0, "error result with nonzero value")
  `CFA_CHECK_NEXT(a_accept_exec, req.valid && req.ready, state == S_EXEC, "accepted word not executed")
  `CFA_CHECK_NEXT(a_err_sticky, state == S_EXEC && !firstq && err != ERR_NONE, err == $past(err) && acc == '0, "error list folded")
endmodule
`default_nettype wire
